// File: design/nbdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbdr_pkg
// Shared widths, constants and controller/datapath interface types for the
// nine-bit datagram receiver.
// ----------------------------------------------------------------------------
package nbdr_pkg;

    localparam int ByteWidth  = 8;
    localparam int PosWidth   = 5;
    localparam int TicksWidth = 12;
    localparam int CountWidth = 13;
    localparam int BitWidth   = 4;

    localparam logic [TicksWidth-1:0] TicksReset = 12'd208;
    localparam logic [3:0]            NibbleMask = 4'hF;
    localparam logic [PosWidth-1:0]   LengthBias = 5'd3;
    localparam logic [BitWidth-1:0]   DataBits   = 4'd8;
    localparam logic [BitWidth-1:0]   MarkerBit  = 4'd8;
    localparam logic [BitWidth-1:0]   StopBit    = 4'd9;

    typedef struct packed {
        logic tick;        // line sample transaction taken this cycle
        logic emit_start;  // stop bit of a complete datagram taken
        logic rd_en;       // read the store at the emit index
        logic next_byte;   // result transaction done, advance emit index
    } nbdr_cmd_t;

    typedef struct packed {
        logic frame_done;  // the sample now offered would close a datagram
        logic last_byte;   // emit index is on the final byte
    } nbdr_status_t;

endpackage
`default_nettype wire

// File: design/nine_bit_datagram_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nine_bit_datagram_receiver_core
// Nine-bit serial receiver with length framing: samples the line once per
// transaction, assembles bytes into a datagram and sends out each complete
// datagram byte by byte, last byte marked.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_line_level (one tick)
//   m_        out        m_valid / m_ready   m_data_byte, m_byte_position,
//                                            m_is_last
//   cfg_      in         cfg_we              cfg_wdata (bit_ticks)
//
// One sample transaction per cycle while a datagram is being assembled.
// After the stop-bit sample of a complete datagram, s_ready stays low while
// each byte is read from the store and presented, and during m_ready stalls.
// Reset is synchronous, active low; bit_ticks resets to 208.
// The datagram store holds no reset value; only written entries are read.
// ----------------------------------------------------------------------------
module nine_bit_datagram_receiver_core
    import nbdr_pkg::*;
#(
    parameter int MAX_DATAGRAM_BYTES = 18
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [TicksWidth-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic                  s_line_level,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [ByteWidth-1:0]  m_data_byte,
    output      logic [PosWidth-1:0]   m_byte_position,
    output      logic                  m_is_last
);

    nbdr_cmd_t    cmd;
    nbdr_status_t status;

    nbdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nbdr_datapath #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .line_level    (s_line_level),
        .cmd           (cmd),
        .status        (status),
        .data_byte     (m_data_byte),
        .byte_position (m_byte_position),
        .is_last       (m_is_last)
    );

endmodule
`default_nettype wire

// File: design/nbdr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 18
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/nbdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbdr_ctrl
// Controller: takes line samples, and after a datagram closes walks its
// bytes out through the store read port and the result channel.
// ----------------------------------------------------------------------------
module nbdr_ctrl
    import nbdr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output      logic         s_ready,
    output      logic         m_valid,
    input  wire logic         m_ready,
    input  wire nbdr_status_t status,
    output      nbdr_cmd_t    cmd
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SHOW = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       s_take;
    logic       m_take;

    assign s_ready = (state_reg == ST_RUN);
    assign m_valid = (state_reg == ST_SHOW);
    assign s_take  = s_valid && s_ready;
    assign m_take  = m_valid && m_ready;

    always_comb begin
        cmd.tick       = s_take;
        cmd.emit_start = s_take && status.frame_done;
        cmd.rd_en      = (state_reg == ST_READ);
        cmd.next_byte  = m_take && !status.last_byte;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_take && status.frame_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                // hold the byte until taken
                if (m_take) begin
                    state_next = status.last_byte ? ST_RUN : ST_READ;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: design/nbdr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbdr_datapath
// Bit timing, byte shift register, datagram store and length framing, plus
// the emit index used while a datagram is sent out.
// ----------------------------------------------------------------------------
module nbdr_datapath
    import nbdr_pkg::*;
#(
    parameter int MAX_DATAGRAM_BYTES = 18
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [TicksWidth-1:0] cfg_wdata,
    input  wire logic                  line_level,
    input  wire nbdr_cmd_t             cmd,
    output      nbdr_status_t          status,
    output      logic [ByteWidth-1:0]  data_byte,
    output      logic [PosWidth-1:0]   byte_position,
    output      logic                  is_last
);

    localparam int AddrWidth = $clog2(MAX_DATAGRAM_BYTES);
    localparam logic [PosWidth-1:0] Limit = PosWidth'(MAX_DATAGRAM_BYTES);

    logic [TicksWidth-1:0] bit_ticks_reg;
    logic                  receiving_reg,  receiving_next;
    logic                  prev_level_reg;
    logic [CountWidth-1:0] countdown_reg,  countdown_next;
    logic [BitWidth-1:0]   bit_pos_reg,    bit_pos_next;
    logic [ByteWidth-1:0]  shift_reg,      shift_next;
    logic [PosWidth-1:0]   held_reg,       held_next;
    logic [PosWidth-1:0]   exp_len_reg,    exp_len_next;
    logic [PosWidth-1:0]   emit_idx_reg;
    logic [PosWidth-1:0]   emit_total_reg;

    logic                  sample_now;
    logic [PosWidth-1:0]   held_base;
    logic                  store_we;
    logic [CountWidth-1:0] first_wait;

    assign first_wait = CountWidth'(bit_ticks_reg) + CountWidth'(bit_ticks_reg >> 1);
    assign sample_now = receiving_reg && (countdown_reg <= CountWidth'(1));

    always_comb begin
        status.frame_done = sample_now && (bit_pos_reg > MarkerBit)
                            && (exp_len_reg != '0) && (held_reg >= exp_len_reg);
        status.last_byte  = (emit_idx_reg + PosWidth'(1)) == emit_total_reg;
    end

    // a command byte drops any partial datagram before it is stored
    assign held_base = (line_level && held_reg != '0) ? '0 : held_reg;

    always_comb begin
        receiving_next = receiving_reg;
        countdown_next = countdown_reg;
        bit_pos_next   = bit_pos_reg;
        shift_next     = shift_reg;
        held_next      = held_reg;
        exp_len_next   = exp_len_reg;
        store_we       = 1'b0;
        if (!receiving_reg) begin
            if (prev_level_reg && !line_level) begin
                receiving_next = 1'b1;
                bit_pos_next   = '0;
                shift_next     = '0;
                countdown_next = first_wait;
            end
        end else if (!sample_now) begin
            countdown_next = countdown_reg - CountWidth'(1);
        end else begin
            countdown_next = CountWidth'(bit_ticks_reg);
            if (bit_pos_reg < DataBits) begin
                shift_next   = shift_reg
                               | (ByteWidth'(line_level) << bit_pos_reg[2:0]);
                bit_pos_next = bit_pos_reg + BitWidth'(1);
            end else if (bit_pos_reg == MarkerBit) begin
                held_next = held_base;
                if (held_base != held_reg) begin
                    exp_len_next = '0;
                end
                if (held_base < Limit) begin
                    store_we  = 1'b1;
                    held_next = held_base + PosWidth'(1);
                    if (held_base == PosWidth'(1)) begin
                        exp_len_next = PosWidth'(shift_reg[3:0] & NibbleMask) + LengthBias;
                    end
                end
                bit_pos_next = StopBit;
            end else begin
                receiving_next = 1'b0;
                bit_pos_next   = '0;
                shift_next     = '0;
                if (status.frame_done) begin
                    held_next    = '0;
                    exp_len_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg  <= TicksReset;
            receiving_reg  <= 1'b0;
            prev_level_reg <= 1'b1;
            countdown_reg  <= '0;
            bit_pos_reg    <= '0;
            shift_reg      <= '0;
            held_reg       <= '0;
            exp_len_reg    <= '0;
            emit_idx_reg   <= '0;
            emit_total_reg <= '0;
        end else begin
            if (cfg_we) begin
                bit_ticks_reg <= cfg_wdata;
            end
            if (cmd.tick) begin
                receiving_reg  <= receiving_next;
                prev_level_reg <= line_level;
                countdown_reg  <= countdown_next;
                bit_pos_reg    <= bit_pos_next;
                shift_reg      <= shift_next;
                held_reg       <= held_next;
                exp_len_reg    <= exp_len_next;
            end
            if (cmd.emit_start) begin
                emit_idx_reg   <= '0;
                emit_total_reg <= held_reg;
            end else if (cmd.next_byte) begin
                emit_idx_reg <= emit_idx_reg + PosWidth'(1);
            end
        end
    end

    nbdr_ram #(
        .WIDTH (ByteWidth),
        .DEPTH (MAX_DATAGRAM_BYTES)
    ) u_store (
        .clk   (aclk),
        .we    (cmd.tick && store_we),
        .waddr (held_base[AddrWidth-1:0]),
        .wdata (shift_reg),
        .re    (cmd.rd_en),
        .raddr (emit_idx_reg[AddrWidth-1:0]),
        .rdata (data_byte)
    );

    assign byte_position = emit_idx_reg;
    assign is_last       = status.last_byte;

endmodule
`default_nettype wire

// File: bench/nine_bit_datagram_receiver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_datagram_receiver_core_test
// Self-checking bench for the nine-bit datagram receiver. Line samples are
// offered one per transaction with bursty timing. A tick-accurate receiver
// model predicts every datagram byte, and each result transaction is checked
// against it in order. A short table of framed bytes comes first, at the
// shortest bit time: data-first, command resync, low stop bits and the
// longest datagram. Random datagrams with noise follow at short bit times.
// ----------------------------------------------------------------------------
module nine_bit_datagram_receiver_core_test;
    import nbdr_pkg::*;

    localparam int DatagramMax    = 18;
    localparam int NumRows        = 6;
    localparam int RandomPhases   = 2;
    localparam int DatagramsEach  = 2;
    localparam int SettleCycles   = 48;
    localparam int LongHoldCycles = 400;
    localparam int QuietLimit     = 4000;

    typedef struct packed {
        logic [ByteWidth-1:0] data;
        logic [PosWidth-1:0]  pos;
        logic                 last;
    } datagram_byte_t;

    // One framed byte of the directed table; emitted is checked when typed is set
    typedef struct packed {
        logic                  marker;
        logic [ByteWidth-1:0]  value;
        logic                  stop_high;
        logic [TicksWidth-1:0] ticks;
        logic [4:0]            copies;
        logic                  typed;
        logic [4:0]            emitted;
    } frame_row_t;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [TicksWidth-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_line_level = 1'b1;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [ByteWidth-1:0]  m_data_byte;
    logic [PosWidth-1:0]   m_byte_position;
    logic                  m_is_last;

    // Receiver model state
    logic [TicksWidth-1:0] bit_ticks_model = TicksReset;
    logic                  rx_busy         = 1'b0;
    logic                  rx_prev_level   = 1'b1;
    logic [CountWidth-1:0] rx_countdown    = '0;
    logic [BitWidth-1:0]   rx_bit_pos      = '0;
    logic [ByteWidth-1:0]  rx_shift        = '0;
    logic [ByteWidth-1:0]  rx_store [DatagramMax];
    logic [PosWidth-1:0]   rx_held         = '0;
    logic [PosWidth-1:0]   rx_length       = '0;

    datagram_byte_t pending_bytes_q [$];
    int             byte_count_q [$];
    logic           line_plan_q [$];
    frame_row_t     directed_rows [NumRows];

    int   mismatches     = 0;
    int   burst_left     = 1;
    int   gap_left       = 0;
    int   quiet_cycles   = 0;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left      = 0;
    int   stall_left     = 0;
    logic [7:0] stall_pattern = 8'hFF;
    logic [2:0] stall_step    = '0;

    nine_bit_datagram_receiver_core #(
        .MAX_DATAGRAM_BYTES(DatagramMax)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line_level    (s_line_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_byte_position (m_byte_position),
        .m_is_last       (m_is_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the receiver model by one line sample
    task automatic receive_tick(input logic level);
        int             i;
        int             emitted;
        int             typed_count;
        datagram_byte_t entry;
        if (!rx_busy) begin
            if (rx_prev_level && !level) begin
                rx_busy      = 1'b1;
                rx_bit_pos   = '0;
                rx_shift     = '0;
                rx_countdown = CountWidth'(bit_ticks_model)
                             + CountWidth'(bit_ticks_model >> 1);
            end
        end else if (rx_countdown > 1) begin
            rx_countdown = rx_countdown - 1'b1;
        end else begin
            rx_countdown = CountWidth'(bit_ticks_model);
            if (rx_bit_pos < DataBits) begin
                if (level)
                    rx_shift[rx_bit_pos[2:0]] = 1'b1;
                rx_bit_pos = rx_bit_pos + 1'b1;
            end else if (rx_bit_pos == MarkerBit) begin
                // a command byte throws away any partial datagram
                if (level && rx_held > 0) begin
                    rx_held   = '0;
                    rx_length = '0;
                end
                if (rx_held < DatagramMax) begin
                    rx_store[rx_held] = rx_shift;
                    rx_held = rx_held + 1'b1;
                end
                if (rx_held == 2)
                    rx_length = PosWidth'(rx_store[1][3:0] & NibbleMask) + LengthBias;
                rx_bit_pos = StopBit;
            end else begin
                rx_busy    = 1'b0;
                rx_bit_pos = '0;
                rx_shift   = '0;
                emitted    = 0;
                if (rx_length != 0 && rx_held >= rx_length) begin
                    for (i = 0; i < rx_held; i++) begin
                        entry.data = rx_store[i];
                        entry.pos  = PosWidth'(i);
                        entry.last = (i + 1 == rx_held);
                        pending_bytes_q.push_back(entry);
                    end
                    emitted   = rx_held;
                    rx_held   = '0;
                    rx_length = '0;
                end
                if (byte_count_q.size() > 0) begin
                    typed_count = byte_count_q.pop_front();
                    if (typed_count >= 0 && typed_count != emitted) begin
                        $error("datagram byte count: expected %0d, got %0d",
                               typed_count, emitted);
                        mismatches++;
                    end
                end
            end
        end
        rx_prev_level = level;
    endtask

    // Check result transactions, feed the model, offer line samples in bursts
    always @(posedge aclk) begin : line_driver
        datagram_byte_t want;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_line_level <= 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_bytes_q.size() == 0) begin
                    $error("unexpected result: byte %0h at position %0d",
                           m_data_byte, m_byte_position);
                    mismatches++;
                end else begin
                    want = pending_bytes_q.pop_front();
                    if (m_data_byte !== want.data) begin
                        $error("m_data_byte: expected %0h, got %0h", want.data, m_data_byte);
                        mismatches++;
                    end
                    if (m_byte_position !== want.pos) begin
                        $error("m_byte_position: expected %0d, got %0d",
                               want.pos, m_byte_position);
                        mismatches++;
                    end
                    if (m_is_last !== want.last) begin
                        $error("m_is_last: expected %0b, got %0b", want.last, m_is_last);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                receive_tick(s_line_level);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (line_plan_q.size() > 0) begin
                    s_valid      <= 1'b1;
                    s_line_level <= line_plan_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(100, 400) : $urandom_range(1, 30);
                        gap_left   = $urandom_range(1, 4);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: a rotating stall pattern per segment, one long hold on request
    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LongHoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_left    = $urandom_range(8, 64);
                    stall_pattern = ($urandom_range(0, 2) == 0) ?
                                    8'hFF : (8'($urandom) | 8'h01);
                end
                stall_left--;
                m_ready    <= stall_pattern[stall_step];
                stall_step  = stall_step + 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QuietLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic plan_level(input logic level, input int unsigned count);
        repeat (count) line_plan_q.push_back(level);
    endtask

    // Start bit, eight data bits LSB first, marker bit, stop bit
    task automatic plan_frame(input logic [ByteWidth-1:0] value, input logic marker,
                              input logic stop_high, input int unsigned bt);
        int b;
        plan_level(1'b0, bt);
        for (b = 0; b < ByteWidth; b++)
            plan_level(value[b], bt);
        plan_level(marker, bt);
        plan_level(stop_high, bt);
    endtask

    task automatic plan_datagram(input int unsigned bt, input int unsigned nib_max,
                                 input logic clean);
        int unsigned          nib;
        int unsigned          count;
        int unsigned          k;
        int unsigned          frame_bt;
        logic [ByteWidth-1:0] b;
        logic                 marker;
        logic                 stop_high;
        nib = (nib_max > 1 && $urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, nib_max);
        count = nib + 3;
        if (!clean && $urandom_range(0, 9) == 0)
            count = $urandom_range(1, count - 1);
        for (k = 0; k < count; k++) begin
            b = 8'($urandom);
            if (k == 1)
                b[3:0] = nib[3:0];
            if (k == 0)
                marker = clean || $urandom_range(0, 9) != 0;
            else
                marker = !clean && $urandom_range(0, 29) == 0;
            stop_high = clean || $urandom_range(0, 14) != 0;
            // skew the bit time now and then
            frame_bt = (!clean && $urandom_range(0, 19) == 0) ?
                       bt + $urandom_range(0, 2) - 1 : bt;
            plan_frame(b, marker, stop_high, frame_bt);
            if (!stop_high || $urandom_range(0, 3) == 0)
                plan_level(1'b1, $urandom_range(1, bt));
            if (!clean && $urandom_range(0, 39) == 0) begin
                repeat ($urandom_range(1, 3 * bt)) line_plan_q.push_back(1'($urandom));
                if ($urandom_range(0, 1) == 1)
                    plan_level(1'b1, 12 * bt);
            end
        end
    endtask

    // Wait until every sample is taken and every byte is out; while the
    // receiver is still mid-frame, hold the line high until it is back
    // waiting for an edge
    task automatic settle_line();
        do begin
            if (rx_busy)
                plan_level(1'b1, 12 * bit_ticks_model + 2);
            while (line_plan_q.size() != 0 || s_valid || pending_bytes_q.size() != 0)
                @(posedge aclk);
            repeat (SettleCycles) @(posedge aclk);
        end while (rx_busy);
    endtask

    task automatic write_bit_ticks(input logic [TicksWidth-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we          <= 1'b0;
        bit_ticks_model  = ticks;
    endtask

    initial begin : stimulus
        int unsigned row;
        int unsigned k;
        int unsigned phase;
        int unsigned dg;
        int unsigned bt;
        directed_rows = '{
            '{1'b0, 8'h81, 1'b1, 12'd1, 5'd1,  1'b0, 5'd0},
            '{1'b0, 8'h01, 1'b0, 12'd1, 5'd1,  1'b0, 5'd0},
            '{1'b1, 8'hC3, 1'b1, 12'd1, 5'd1,  1'b0, 5'd0},
            '{1'b0, 8'h0F, 1'b0, 12'd1, 5'd1,  1'b0, 5'd0},
            '{1'b0, 8'hA5, 1'b1, 12'd1, 5'd15, 1'b0, 5'd0},
            '{1'b0, 8'h5A, 1'b1, 12'd1, 5'd1,  1'b1, 5'd18}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < NumRows; row++) begin
            if (directed_rows[row].ticks != bit_ticks_model) begin
                settle_line();
                write_bit_ticks(directed_rows[row].ticks);
            end
            for (k = 1; k <= directed_rows[row].copies; k++) begin
                byte_count_q.push_back((k == directed_rows[row].copies &&
                                        directed_rows[row].typed) ?
                                       int'(directed_rows[row].emitted) : -1);
                plan_frame(directed_rows[row].value, directed_rows[row].marker,
                           directed_rows[row].stop_high, directed_rows[row].ticks);
                // a low stop bit needs the line back high before the next start
                plan_level(1'b1, directed_rows[row].stop_high ? 0 : 1);
            end
        end

        for (phase = 0; phase < RandomPhases; phase++) begin
            bt = (phase == 0) ? 1 : 2;
            // wait for every byte before touching the bit time
            settle_line();
            write_bit_ticks(TicksWidth'(bt));
            // stall the result side while samples keep coming
            if (phase == 0)
                long_hold_req = 1'b1;
            for (dg = 0; dg < DatagramsEach; dg++)
                plan_datagram(bt, (phase == 0) ? 1 : 0, phase == 0 && dg == 0);
        end
        settle_line();

        if (mismatches == 0 && pending_bytes_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
